### hdl/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// Shared widths, register indexes, reset values and helpers for the
// escape-time fractal pixel evaluator.
// ----------------------------------------------------------------------------
package etf_pkg;

   // Word and field widths
   localparam int WORD_W    = 32;
   localparam int ACC_W     = 66;
   localparam int PROD_W    = 2 * WORD_W;
   localparam int PIXEL_W   = 9;
   localparam int COUNT_W   = 10;
   localparam int STEP_W    = 31;
   localparam int CSR_IDX_W = 3;

   // Defaults for the top-level parameters
   localparam int DEF_WINDOW    = 512;
   localparam int DEF_FRAC_BITS = 28;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_ITER    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_JULIA_REAL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_JULIA_IMAG  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_REAL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CENTER_IMAG = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_PIXEL_STEP  = 3'd6;

   // Register reset values
   localparam logic                       MODE_RST        = 1'b0;
   localparam logic [COUNT_W-1:0]         MAX_ITER_RST    = 10'd100;
   localparam logic signed [WORD_W-1:0]   JULIA_REAL_RST  = -32'sd48318382;
   localparam logic signed [WORD_W-1:0]   JULIA_IMAG_RST  = -32'sd179851756;
   localparam logic signed [WORD_W-1:0]   CENTER_REAL_RST = 32'sd0;
   localparam logic signed [WORD_W-1:0]   CENTER_IMAG_RST = 32'sd0;
   localparam logic [STEP_W-1:0]          PIXEL_STEP_RST  = 31'd2097152;

   // Clamp a wide sum to the signed word range
   function automatic logic signed [WORD_W-1:0] sat_word(
      input logic signed [ACC_W-1:0] v
   );
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = {{(ACC_W-WORD_W+1){1'b0}}, {(WORD_W-1){1'b1}}};
      lo = -hi - ACC_W'(1);
      if (v > hi) begin
         return hi[WORD_W-1:0];
      end else if (v < lo) begin
         return lo[WORD_W-1:0];
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

   // Sign-extend a word to the accumulator width
   function automatic logic signed [ACC_W-1:0] ext_word(
      input logic signed [WORD_W-1:0] v
   );
      return {{(ACC_W-WORD_W){v[WORD_W-1]}}, v};
   endfunction

endpackage

### hdl/etf_req_if.sv
// ----------------------------------------------------------------------------
// etf_req_if
// Pixel request channel: valid/ready handshake with the pixel coordinate.
// ----------------------------------------------------------------------------
interface etf_req_if;
   logic                        valid;
   logic                        ready;
   logic [etf_pkg::PIXEL_W-1:0] pixel_x;
   logic [etf_pkg::PIXEL_W-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### hdl/etf_rsp_if.sv
// ----------------------------------------------------------------------------
// etf_rsp_if
// Result channel: valid/ready handshake with the escape count.
// ----------------------------------------------------------------------------
interface etf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [etf_pkg::COUNT_W-1:0] escape_count;

   modport source (output valid, output escape_count, input ready);
   modport sink   (input valid, input escape_count, output ready);
endinterface

### hdl/escape_time_fractal_pixel.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel
// Maps one pixel to a point of the complex plane and counts the iterations
// of z = z^2 + c until the point leaves the square |re|,|im| <= 2 (zero if it never leaves within the limit).
// ----------------------------------------------------------------------------
// One pixel item is taken at a time. Mapping the pixel runs through the
// states MAP_X, MAP_Y and MAP_I; each iteration runs through MUL_RR,
// MUL_II and MUL_RI (three products through the single shared 32x32
// multiplier) and UPDATE (combine, saturate and test). OUT then hands the
// count to the output register once that register is free, and the next
// pixel can be taken after OUT returns to IDLE.
// The request side is ready only while the sequencer is idle; a finished
// count waits in the output register while the next pixel is taken.
// Registers are to be written through the csr_ port while no pixel is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel #(
   parameter int WINDOW    = etf_pkg::DEF_WINDOW,
   parameter int FRAC_BITS = etf_pkg::DEF_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   etf_req_if.sink                       req_chan,
   etf_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [etf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [etf_pkg::WORD_W-1:0]    csr_wdata
);
   import etf_pkg::*;

   localparam logic signed [WORD_W-1:0] HALF      = WORD_W'(WINDOW / 2);
   localparam logic signed [ACC_W-1:0]  ESC_POS   = ACC_W'(2) << FRAC_BITS;
   localparam logic signed [ACC_W-1:0]  ESC_NEG   = -ESC_POS;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAP_X,
      S_MAP_Y,
      S_MAP_I,
      S_MUL_RR,
      S_MUL_II,
      S_MUL_RI,
      S_UPDATE,
      S_OUT
   } state_type;

   // Configuration registers
   logic                      mode_ff;
   logic [COUNT_W-1:0]        max_iter_ff;
   logic signed [WORD_W-1:0]  julia_re_ff;
   logic signed [WORD_W-1:0]  julia_im_ff;
   logic signed [WORD_W-1:0]  ctr_re_ff;
   logic signed [WORD_W-1:0]  ctr_im_ff;
   logic [STEP_W-1:0]         step_ff;

   // Sequencer and datapath registers
   state_type                 state_ff, state_in;
   logic [PIXEL_W-1:0]        px_ff, px_in;
   logic [PIXEL_W-1:0]        py_ff, py_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [WORD_W-1:0]  pr_ff, pr_in;
   logic signed [WORD_W-1:0]  zr_ff, zr_in;
   logic signed [WORD_W-1:0]  zi_ff, zi_in;
   logic signed [WORD_W-1:0]  cr_ff, cr_in;
   logic signed [WORD_W-1:0]  ci_ff, ci_in;
   logic signed [ACC_W-1:0]   t_ff, t_in;
   logic [COUNT_W-1:0]        iter_ff, iter_in;
   logic [COUNT_W-1:0]        result_ff, result_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Combinational datapath
   logic signed [WORD_W-1:0]  mul_a;
   logic signed [WORD_W-1:0]  mul_b;
   logic signed [WORD_W-1:0]  dx;
   logic signed [WORD_W-1:0]  dy;
   logic signed [WORD_W-1:0]  step_word;
   logic signed [ACC_W-1:0]   prod_ext;
   logic signed [ACC_W-1:0]   prod_sh;
   logic signed [ACC_W-1:0]   prod_sh2;
   logic signed [WORD_W-1:0]  pi_word;
   logic signed [WORD_W-1:0]  nr;
   logic signed [WORD_W-1:0]  ni;
   logic signed [ACC_W-1:0]   nr_ext;
   logic signed [ACC_W-1:0]   ni_ext;
   logic                      escaped;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_RST;
         max_iter_ff <= MAX_ITER_RST;
         julia_re_ff <= JULIA_REAL_RST;
         julia_im_ff <= JULIA_IMAG_RST;
         ctr_re_ff   <= CENTER_REAL_RST;
         ctr_im_ff   <= CENTER_IMAG_RST;
         step_ff     <= PIXEL_STEP_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_MODE:        mode_ff     <= csr_wdata[0];
            REG_MAX_ITER:    max_iter_ff <= csr_wdata[COUNT_W-1:0];
            REG_JULIA_REAL:  julia_re_ff <= csr_wdata;
            REG_JULIA_IMAG:  julia_im_ff <= csr_wdata;
            REG_CENTER_REAL: ctr_re_ff   <= csr_wdata;
            REG_CENTER_IMAG: ctr_im_ff   <= csr_wdata;
            REG_PIXEL_STEP:  step_ff     <= csr_wdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Pixel offsets from the window center
   assign dx        = $signed({{(WORD_W-PIXEL_W){1'b0}}, px_ff}) - HALF;
   assign dy        = $signed({{(WORD_W-PIXEL_W){1'b0}}, py_ff}) - HALF;
   assign step_word = $signed({1'b0, step_ff});

   // Shared multiplier, registered every cycle
   assign prod_in  = mul_a * mul_b;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign prod_sh  = prod_ext >>> FRAC_BITS;
   assign prod_sh2 = prod_ext >>> (FRAC_BITS - 1);

   // Imaginary part of the mapped point
   assign pi_word = sat_word(ext_word(ctr_im_ff) - prod_ext);

   // New z and escape test
   assign nr      = sat_word(t_ff);
   assign ni      = sat_word(prod_sh2 + ext_word(ci_ff));
   assign nr_ext  = ext_word(nr);
   assign ni_ext  = ext_word(ni);
   assign escaped = (nr_ext > ESC_POS) || (nr_ext < ESC_NEG) ||
                    (ni_ext > ESC_POS) || (ni_ext < ESC_NEG);

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      pr_in        = pr_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      t_in         = t_ff;
      iter_in      = iter_ff;
      result_in    = result_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      mul_a        = zr_ff;
      mul_b        = zr_ff;

      // Drop the output item once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               px_in    = req_chan.pixel_x;
               py_in    = req_chan.pixel_y;
               state_in = S_MAP_X;
            end
         end
         S_MAP_X: begin
            mul_a    = dx;
            mul_b    = step_word;
            state_in = S_MAP_Y;
         end
         S_MAP_Y: begin
            pr_in    = sat_word(prod_ext + ext_word(ctr_re_ff));
            mul_a    = dy;
            mul_b    = step_word;
            state_in = S_MAP_I;
         end
         S_MAP_I: begin
            if (mode_ff) begin
               zr_in = pr_ff;
               zi_in = pi_word;
               cr_in = julia_re_ff;
               ci_in = julia_im_ff;
            end else begin
               zr_in = '0;
               zi_in = '0;
               cr_in = pr_ff;
               ci_in = pi_word;
            end
            iter_in = COUNT_W'(1);
            if (max_iter_ff == '0) begin
               result_in = '0;
               state_in  = S_OUT;
            end else begin
               state_in  = S_MUL_RR;
            end
         end
         S_MUL_RR: begin
            mul_a    = zr_ff;
            mul_b    = zr_ff;
            state_in = S_MUL_II;
         end
         S_MUL_II: begin
            t_in     = prod_sh;
            mul_a    = zi_ff;
            mul_b    = zi_ff;
            state_in = S_MUL_RI;
         end
         S_MUL_RI: begin
            t_in     = t_ff - prod_sh + ext_word(cr_ff);
            mul_a    = zr_ff;
            mul_b    = zi_ff;
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (escaped) begin
               result_in = iter_ff;
               state_in  = S_OUT;
            end else if (iter_ff >= max_iter_ff) begin
               result_in = '0;
               state_in  = S_OUT;
            end else begin
               zr_in    = nr;
               zi_in    = ni;
               iter_in  = iter_ff + COUNT_W'(1);
               state_in = S_MUL_RR;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               count_in     = result_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      px_ff     <= px_in;
      py_ff     <= py_in;
      prod_ff   <= prod_in;
      pr_ff     <= pr_in;
      zr_ff     <= zr_in;
      zi_ff     <= zi_in;
      cr_ff     <= cr_in;
      ci_ff     <= ci_in;
      t_ff      <= t_in;
      result_ff <= result_in;
      count_ff  <= count_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= COUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_chan.ready        = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.escape_count = count_ff;

   // An accepted pixel starts the mapping
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff == S_MAP_X))
      else $error("accepted pixel did not start mapping");

   // A finished pixel reaches the output register when the slot is free
   a_out_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && (!rsp_valid_ff || rsp_chan.ready)) |=> rsp_valid_ff)
      else $error("finished count not presented");

   // The iteration counter never wraps to zero inside the loop
   a_iter_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL_RR) |-> (iter_ff != '0))
      else $error("iteration counter wrapped");

endmodule

### tb/sv/escape_time_fractal_pixel_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// escape_time_fractal_pixel_checker
// Watches the pixel, result and register ports of the escape-time evaluator.
// Keeps its own copy of the registers, predicts the escape count of every
// accepted pixel and compares each accepted result against the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module escape_time_fractal_pixel_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [etf_pkg::PIXEL_W-1:0]   req_pixel_x,
   input  logic [etf_pkg::PIXEL_W-1:0]   req_pixel_y,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [etf_pkg::COUNT_W-1:0]   rsp_escape_count,
   input  logic                          csr_wr_en,
   input  logic [etf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [etf_pkg::WORD_W-1:0]    csr_wdata,
   output int                            error_count,
   output int                            pending_count
);
   import etf_pkg::*;

   localparam int     FRAC         = DEF_FRAC_BITS;
   localparam longint HALF_WINDOW  = longint'(DEF_WINDOW / 2);
   localparam longint WORD_HI      = 64'sd2147483647;
   localparam longint WORD_LO      = -WORD_HI - 64'sd1;
   localparam longint ESCAPE_BOUND = 64'sd2 <<< FRAC;

   // Shadow copy of the register file
   logic                     julia_mode;
   logic [COUNT_W-1:0]       iter_limit;
   logic signed [WORD_W-1:0] julia_re;
   logic signed [WORD_W-1:0] julia_im;
   logic signed [WORD_W-1:0] center_re;
   logic signed [WORD_W-1:0] center_im;
   logic [STEP_W-1:0]        plane_step;

   // Escape counts of pixels taken but not yet answered, oldest first
   logic [COUNT_W-1:0] expected_counts[$];

   function automatic longint clamp_word(input longint v);
      if (v > WORD_HI) begin
         return WORD_HI;
      end
      if (v < WORD_LO) begin
         return WORD_LO;
      end
      return v;
   endfunction

   // Map the pixel to the plane, then iterate z = z^2 + c until it leaves
   // the square of half-width 2; products round toward minus infinity
   function automatic logic [COUNT_W-1:0] escape_iteration(
      input logic [PIXEL_W-1:0] px,
      input logic [PIXEL_W-1:0] py
   );
      longint dx, dy, stride, pr, pim, zr, zi, cr, ci, nr, ni;
      logic [COUNT_W-1:0] hit;
      stride = longint'(plane_step);
      dx     = longint'(px) - HALF_WINDOW;
      dy     = longint'(py) - HALF_WINDOW;
      pr     = clamp_word(dx * stride + longint'(center_re));
      pim    = clamp_word(longint'(center_im) - dy * stride);
      if (julia_mode) begin
         zr = pr;
         zi = pim;
         cr = longint'(julia_re);
         ci = longint'(julia_im);
      end else begin
         zr = 0;
         zi = 0;
         cr = pr;
         ci = pim;
      end
      hit = '0;
      for (int k = 1; k <= int'(iter_limit); k++) begin
         nr = clamp_word(((zr * zr) >>> FRAC) - ((zi * zi) >>> FRAC) + cr);
         ni = clamp_word(((zr * zi) >>> (FRAC - 1)) + ci);
         if (nr > ESCAPE_BOUND || nr < -ESCAPE_BOUND ||
             ni > ESCAPE_BOUND || ni < -ESCAPE_BOUND) begin
            hit = COUNT_W'(k);
            break;
         end
         zr = nr;
         zi = ni;
      end
      return hit;
   endfunction

   always @(posedge clock) begin : watch
      logic [COUNT_W-1:0] want;
      if (reset) begin
         julia_mode  <= MODE_RST;
         iter_limit  <= MAX_ITER_RST;
         julia_re    <= JULIA_REAL_RST;
         julia_im    <= JULIA_IMAG_RST;
         center_re   <= CENTER_REAL_RST;
         center_im   <= CENTER_IMAG_RST;
         plane_step  <= PIXEL_STEP_RST;
         expected_counts.delete();
         error_count   <= 0;
         pending_count <= 0;
      end else begin
         // Track register writes; unknown indexes are dropped
         if (csr_wr_en) begin
            case (csr_index)
               REG_MODE:        julia_mode <= csr_wdata[0];
               REG_MAX_ITER:    iter_limit <= csr_wdata[COUNT_W-1:0];
               REG_JULIA_REAL:  julia_re   <= csr_wdata;
               REG_JULIA_IMAG:  julia_im   <= csr_wdata;
               REG_CENTER_REAL: center_re  <= csr_wdata;
               REG_CENTER_IMAG: center_im  <= csr_wdata;
               REG_PIXEL_STEP:  plane_step <= csr_wdata[STEP_W-1:0];
               default: ;
            endcase
         end

         // Predict every accepted pixel item
         if (req_valid && req_ready) begin
            expected_counts.push_back(escape_iteration(req_pixel_x, req_pixel_y));
         end

         // Compare every accepted result item with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               $error("escape_count: expected nothing, actual %0d", rsp_escape_count);
               error_count <= error_count + 1;
            end else begin
               want = expected_counts.pop_front();
               if (want !== rsp_escape_count) begin
                  $error("escape_count: expected %0d, actual %0d",
                         want, rsp_escape_count);
                  error_count <= error_count + 1;
               end
            end
         end

         pending_count <= expected_counts.size();
      end
   end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives pixels and register settings into the escape-time evaluator while a
// side checker predicts and compares every escape count. A directed part
// covers corners, zero limit, zero step, exact boundary points, mapping
// saturation and unused register writes; random phases follow with varied
// settings and back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import etf_pkg::*;

   localparam int                   RANDOM_ITEMS    = 1500;
   localparam int                   QUIET_LIMIT     = 20000;
   localparam int                   SETTLE_CYCLES   = 50;
   localparam logic                 MODE_MANDELBROT = 1'b0;
   localparam logic                 MODE_JULIA      = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED      = 3'd7;

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [WORD_W-1:0]    csr_wdata;
   int                   error_count;
   int                   pending_count;
   int                   send_idle_pct;
   int                   take_idle_pct;
   int                   quiet_cycles;

   etf_req_if req_chan ();
   etf_rsp_if rsp_chan ();

   escape_time_fractal_pixel dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   escape_time_fractal_pixel_checker escape_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_ready        (req_chan.ready),
      .req_pixel_x      (req_chan.pixel_x),
      .req_pixel_y      (req_chan.pixel_y),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_escape_count (rsp_chan.escape_count),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .error_count      (error_count),
      .pending_count    (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the result side at random
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= take_idle_pct);
   end

   // End the run when no item moves for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("escape_time_fractal_pixel: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one pixel item, after a random idle gap, and hold it until taken
   task automatic send_pixel(input logic [PIXEL_W-1:0] x, input logic [PIXEL_W-1:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.pixel_x <= x;
      req_chan.pixel_y <= y;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold off new pixels until every predicted count has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Drain, then rewrite the whole register file
   task automatic load_config(
      input logic                 m,
      input logic [COUNT_W-1:0]   limit,
      input logic [WORD_W-1:0]    jr,
      input logic [WORD_W-1:0]    ji,
      input logic [WORD_W-1:0]    cr,
      input logic [WORD_W-1:0]    ci,
      input logic [STEP_W-1:0]    st,
      input bit                   touch_unused
   );
      wait_drained();
      write_reg(REG_MODE, WORD_W'(m));
      write_reg(REG_MAX_ITER, WORD_W'(limit));
      write_reg(REG_JULIA_REAL, jr);
      write_reg(REG_JULIA_IMAG, ji);
      write_reg(REG_CENTER_REAL, cr);
      write_reg(REG_CENTER_IMAG, ci);
      write_reg(REG_PIXEL_STEP, WORD_W'(st));
      if (touch_unused) begin
         write_reg(REG_UNUSED, '1);
      end
      csr_wr_en <= 1'b0;
   endtask

   // Plane coordinate: mostly within +-2, sometimes any word
   function automatic logic [WORD_W-1:0] plane_value();
      if ($urandom_range(4) == 0) begin
         return $urandom;
      end
      return WORD_W'(int'($urandom_range(32'h4000_0000)) - 32'sh2000_0000);
   endfunction

   initial begin : stimulus
      int                 sent;
      int                 batch;
      int                 pick;
      logic               mode_pick;
      logic [COUNT_W-1:0] limit_pick;
      logic [STEP_W-1:0]  step_pick;

      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req_chan.valid   = 1'b0;
      req_chan.pixel_x = '0;
      req_chan.pixel_y = '0;
      send_idle_pct    = 16;
      take_idle_pct    = 75;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: window corners and the origin, which never escapes
      send_pixel(9'd0, 9'd0);
      send_pixel(9'd511, 9'd511);
      send_pixel(9'd256, 9'd256);
      send_pixel(9'd511, 9'd0);
      send_pixel(9'd0, 9'd511);
      send_pixel(9'd255, 9'd255);
      send_pixel(9'd320, 9'd200);

      // Julia set at the full iteration limit
      load_config(MODE_JULIA, 10'd1023, -32'sd214748365, 32'sd41875931,
                  32'sd0, 32'sd0, 31'd2097152, 1'b0);
      send_pixel(9'd256, 9'd256);
      send_pixel(9'd100, 9'd400);
      send_pixel(9'd511, 9'd511);

      // Zero limit, zero step, and a write to an unused index
      load_config(MODE_MANDELBROT, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h1234_5678, 32'hEDCB_A987, 31'd0, 1'b1);
      send_pixel(9'd0, 9'd0);
      send_pixel(9'd511, 9'd511);

      // Mapping saturates at both ends of the word range
      load_config(MODE_MANDELBROT, 10'd5, 32'h0, 32'h0,
                  32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
      send_pixel(9'd511, 9'd0);
      send_pixel(9'd0, 9'd511);
      send_pixel(9'd256, 9'd256);

      // Points on and next to the real boundary at -2
      load_config(MODE_MANDELBROT, 10'd50, 32'h0, 32'h0,
                  32'hE000_0000, 32'h0, 31'd1, 1'b0);
      send_pixel(9'd256, 9'd256);
      send_pixel(9'd257, 9'd256);
      send_pixel(9'd255, 9'd256);

      // Julia constant at the word extremes
      load_config(MODE_JULIA, 10'd1023, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h0, 32'h0, 31'd4194304, 1'b0);
      send_pixel(9'd256, 9'd256);
      send_pixel(9'd0, 9'd0);

      // Random phases: new settings each phase, idling pattern by progress
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent < RANDOM_ITEMS / 3) begin
            send_idle_pct = 16;
            take_idle_pct = 75;
         end else if (sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 75;
            take_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end
         mode_pick = 1'($urandom_range(1));
         pick = int'($urandom_range(19));
         if (pick == 0) begin
            limit_pick = 10'd1023;
            batch      = 8;
         end else if (pick <= 3) begin
            limit_pick = COUNT_W'($urandom_range(255, 41));
            batch      = 30;
         end else begin
            limit_pick = COUNT_W'($urandom_range(40, 1));
            batch      = 60;
         end
         if ($urandom_range(9) == 0) begin
            step_pick = STEP_W'($urandom_range(32'h7FFF_FFFF, 1));
         end else begin
            step_pick = STEP_W'($urandom_range(32'h0040_0000, 32'h0000_1000));
         end
         load_config(mode_pick, limit_pick, plane_value(), plane_value(),
                     plane_value(), plane_value(), step_pick, 1'b0);
         for (int n = 0; n < batch; n++) begin
            if ($urandom_range(39) == 0) begin
               wait_drained();
            end
            send_pixel(PIXEL_W'($urandom_range(511)), PIXEL_W'($urandom_range(511)));
         end
         sent += batch;
      end

      // Drain, let stray results show up, then give the verdict
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("escape_time_fractal_pixel: match");
      end else begin
         $display("escape_time_fractal_pixel: mismatch");
      end
      $finish;
   end

endmodule
